@@ hdl/itaf_pkg.sv @@
// Package for the integer to ASCII formatter.
// Holds the payload structs, format codes, front-end states and digit helpers.
// No dependencies.
`default_nettype none
package itaf_pkg;
	localparam int MAX_DIGITS = 10;
	localparam int MAX_CHARS  = 11;
	localparam int Q_DEPTH    = 2;
	localparam int Q_AW       = $clog2(Q_DEPTH);

	// ceil(2^35 / 10); (x * RECIP10) >> 35 == x / 10 for every 32-bit x
	localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_LC_A  = 8'h61;
	localparam logic [7:0] CHAR_UC_A  = 8'h41;

	typedef enum logic [1:0] {
		FMT_SDEC = 2'd0,
		FMT_UDEC = 2'd1,
		FMT_HEXL = 2'd2,
		FMT_HEXU = 2'd3
	} fmt_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CONV,
		F_PUSH
	} front_state_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       is_last;
		logic [3:0] char_count;
	} out_item_t;

	// One converted number: digits most significant in slot 0
	typedef struct packed {
		logic [MAX_DIGITS-1:0][3:0] digs;
		logic [3:0]                 ndig;
		logic                       neg;
		logic                       upper;
	} job_t;

	function automatic logic [7:0] digit_ascii(input logic [3:0] d, input logic upper);
		logic [7:0] res;
		if (d < 4'd10) begin
			res = CHAR_ZERO + {4'd0, d};
		end else if (upper) begin
			res = CHAR_UC_A + {4'd0, d} - 8'd10;
		end else begin
			res = CHAR_LC_A + {4'd0, d} - 8'd10;
		end
		return res;
	endfunction
endpackage
`default_nettype wire

@@ hdl/integer_to_ascii_formatter.sv @@
// Integer to ASCII formatter, top level.
// Uses itaf_pkg, itaf_front, itaf_queue and itaf_back.
//
// Input channel (in_valid/in_ready/in_data): one 32-bit value and a format
// (signed decimal, unsigned decimal, lowercase hex, uppercase hex) per transfer.
// Output channel (out_valid/out_ready/out_data): one ASCII character per
// transfer, most significant first, sign first for negative signed values.
// The final character of a number has is_last set and carries the count.
// Conversion: a number yields one digit per cycle (reciprocal multiply for
// decimal, nibble shift for hex); the finished job then enters the job queue
// and is loaded into the output side before its first character is sent.
// The output side sends one character a cycle while the receiver is ready,
// and meanwhile the front converts the next number.
// Reset clears the control state of all three parts; the queue empties.
// When the receiver stalls, the output register holds its character, the
// back end stops, the two-entry queue fills, the front holds its finished
// job and in_ready stays low.
`default_nettype none
module integer_to_ascii_formatter (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire itaf_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output itaf_pkg::out_item_t      out_data
);
	import itaf_pkg::*;

	logic fq_valid;
	logic fq_ready;
	job_t fq_data;
	logic qb_valid;
	logic qb_ready;
	job_t qb_data;

	itaf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.job_valid (fq_valid),
		.job_ready (fq_ready),
		.job_data  (fq_data)
	);

	itaf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_data  (fq_data),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_data  (qb_data)
	);

	itaf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qb_valid),
		.job_ready (qb_ready),
		.job_data  (qb_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);
endmodule
`default_nettype wire

@@ hdl/itaf_front.sv @@
// Front end: accepts a number, takes the magnitude and produces one digit
// per cycle (reciprocal multiply for decimal, nibble shift for hex). Uses itaf_pkg.
`default_nettype none
module itaf_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire itaf_pkg::in_item_t in_data,
	output logic                   job_valid,
	input  wire logic              job_ready,
	output itaf_pkg::job_t         job_data
);
	import itaf_pkg::*;

	front_state_t               state_q, state_d;
	logic [31:0]                mag_q;
	logic [MAX_DIGITS-1:0][3:0] digs_q;
	logic [3:0]                 nd_q;
	logic                       neg_q;
	logic                       upper_q;
	logic                       hex_q;

	logic [63:0] prod;
	logic [31:0] quot;
	logic [3:0]  q10_lo;
	logic [3:0]  digit;
	logic [31:0] mag_next;
	logic        conv_done;
	logic        in_neg;
	fmt_t        in_fmt;

	assign in_fmt = fmt_t'(in_data.req_type);
	assign in_neg = (in_fmt == FMT_SDEC) && in_data.value[31];

	// digit = mag - 10*(mag/10), only the low nibble matters
	assign prod   = {32'd0, mag_q} * {32'd0, RECIP10};
	assign quot   = {3'd0, prod[63:RECIP_SHIFT]};
	assign q10_lo = {quot[2:0], 1'b0} + {quot[0], 3'b000};

	always_comb begin
		if (hex_q) begin
			digit    = mag_q[3:0];
			mag_next = {4'd0, mag_q[31:4]};
		end else begin
			digit    = mag_q[3:0] - q10_lo;
			mag_next = quot;
		end
	end

	assign conv_done = (mag_next == 32'd0) || (nd_q == 4'(MAX_DIGITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		job_valid = 1'b0;
		case (state_q)
			F_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = F_CONV;
				end
			end
			F_CONV: begin
				if (conv_done) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				job_valid = 1'b1;
				if (job_ready) begin
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			mag_q   <= in_neg ? (~in_data.value + 32'd1) : in_data.value;
			neg_q   <= in_neg;
			hex_q   <= (in_fmt == FMT_HEXL) || (in_fmt == FMT_HEXU);
			upper_q <= (in_fmt == FMT_HEXU);
			nd_q    <= 4'd0;
		end else if (state_q == F_CONV) begin
			mag_q  <= mag_next;
			digs_q <= {digs_q[MAX_DIGITS-2:0], digit};
			nd_q   <= nd_q + 4'd1;
		end
	end

	assign job_data.digs  = digs_q;
	assign job_data.ndig  = nd_q;
	assign job_data.neg   = neg_q;
	assign job_data.upper = upper_q;

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == F_PUSH |-> (nd_q != 4'd0 && nd_q <= 4'(MAX_DIGITS)))
		else $error("front pushes a job with a bad digit count");

	a_conv_dec_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_CONV && !hex_q) |-> digit < 4'd10)
		else $error("decimal digit out of range");
endmodule
`default_nettype wire

@@ hdl/itaf_queue.sv @@
// Short job queue between the front and back ends.
// Uses itaf_pkg for the job record type and depth.
`default_nettype none
module itaf_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_valid,
	output logic                wr_ready,
	input  wire itaf_pkg::job_t wr_data,
	output logic                rd_valid,
	input  wire logic           rd_ready,
	output itaf_pkg::job_t      rd_data
);
	import itaf_pkg::*;

	job_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;
	logic            push;
	logic            pop;

	assign wr_ready = (count_q != (Q_AW+1)'(Q_DEPTH));
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end
endmodule
`default_nettype wire

@@ hdl/itaf_back.sv @@
// Back end: takes converted jobs and streams their characters, sign first,
// through a registered output stage. Uses itaf_pkg.
`default_nettype none
module itaf_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           job_valid,
	output logic                job_ready,
	input  wire itaf_pkg::job_t job_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output itaf_pkg::out_item_t out_data
);
	import itaf_pkg::*;

	logic                       busy_q;
	logic [MAX_DIGITS-1:0][3:0] digs_q;
	logic [3:0]                 left_q;
	logic                       neg_q;
	logic                       upper_q;
	logic [3:0]                 total_q;
	logic                       out_valid_q;
	out_item_t                  out_q;
	logic                       adv;
	logic                       fin;

	assign adv       = !out_valid_q || out_ready;
	assign job_ready = !busy_q;
	assign fin       = !neg_q && (left_q == 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (!busy_q) begin
			if (job_valid) begin
				busy_q <= 1'b1;
			end
			if (adv) begin
				out_valid_q <= 1'b0;
			end
		end else if (adv) begin
			out_valid_q <= 1'b1;
			if (fin) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			if (job_valid) begin
				digs_q  <= job_data.digs;
				left_q  <= job_data.ndig;
				neg_q   <= job_data.neg;
				upper_q <= job_data.upper;
				total_q <= job_data.ndig + {3'd0, job_data.neg};
			end
		end else if (adv) begin
			if (neg_q) begin
				out_q.char_out   <= CHAR_MINUS;
				out_q.is_last    <= 1'b0;
				out_q.char_count <= 4'd0;
				neg_q            <= 1'b0;
			end else begin
				out_q.char_out   <= digit_ascii(digs_q[0], upper_q);
				out_q.is_last    <= fin;
				out_q.char_count <= fin ? total_q : 4'd0;
				digs_q           <= {4'd0, digs_q[MAX_DIGITS-1:1]};
				left_q           <= left_q - 4'd1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_count_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.is_last) |-> out_q.char_count == 4'd0)
		else $error("character count on a non-final character");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.is_last) |->
			(out_q.char_count != 4'd0 && out_q.char_count <= 4'(MAX_CHARS)))
		else $error("final character count out of range");

	a_digits_pending: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> left_q != 4'd0)
		else $error("back end busy with no digits left");
endmodule
`default_nettype wire
